/* rtl/qts_pkg.sv */
package qts_pkg;

  // fixed widths of the data path
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int DUR_W   = 31;
  localparam int POS_W   = 32;
  localparam int STAT_W  = 2;
  localparam int Q_W     = 31;   // quotient bits of each divide lane
  localparam int REM_W   = 11;   // divide remainder, below the span
  localparam int S_BITS  = 30;   // normalized time is Q1.30
  localparam int WIDE_W  = 64;

  localparam int DEF_MAX_SAMPLES   = 1024;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic signed [WIDE_W-1:0] SAT_CAP = 64'sd1 <<< 61;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ZERO_DUR  = 2'd2;

  typedef enum logic [2:0] {
    REG_START_POS = 3'd0,
    REG_START_VEL = 3'd1,
    REG_START_ACC = 3'd2,
    REG_END_POS   = 3'd3,
    REG_END_VEL   = 3'd4,
    REG_END_ACC   = 3'd5,
    REG_DURATION  = 3'd6,
    REG_COUNT     = 3'd7
  } qts_reg_t;

  // tag that rides along the divide chain
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
  } qts_tag_t;

  // tag that rides along the evaluation pipeline
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [DUR_W-1:0]  time_q;
  } qts_side_t;

  function automatic logic signed [WIDE_W-1:0] sat_add(
    input logic signed [WIDE_W-1:0] a,
    input logic signed [WIDE_W-1:0] b
  );
    logic signed [WIDE_W-1:0] sum;
    sum = a + b;
    if (sum > SAT_CAP) begin
      return SAT_CAP;
    end else if (sum < -SAT_CAP) begin
      return -SAT_CAP;
    end
    return sum;
  endfunction

endpackage

/* rtl/quintic_trajectory_sampler_core.sv */
// channel   direction  signals                                  beat taken when
// command   in         start, busy, sample_index                start & !busy
// result    out        done, sample_time, position, status      done (one cycle)
// config    in/out     psel, penable, pwrite, paddr, pwdata,    psel & penable & pwrite
//                      prdata, pready
//
// one beat accepted every cycle; busy stays low, there is no clearing pass
// the pipeline holds one input stage, 31 divide cells and 13 evaluation stages
// the divide chain sets the depth: one quotient bit per cell for s and for time
// reset (synchronous, active high) empties the pipeline and loads register defaults
// the receiver cannot stall, so results leave on done regardless of traffic
module quintic_trajectory_sampler_core #(
  parameter int MAX_SAMPLES   = qts_pkg::DEF_MAX_SAMPLES,
  parameter int FRACTION_BITS = qts_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic [qts_pkg::IDX_W-1:0]           sample_index,
  // result
  output logic                                done,
  output logic [qts_pkg::DUR_W-1:0]           sample_time,
  output logic signed [qts_pkg::POS_W-1:0]    position,
  output logic [qts_pkg::STAT_W-1:0]          status,
  // config
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int NCELL = qts_pkg::Q_W;

  // configuration registers
  logic signed [qts_pkg::POS_W-1:0] start_position, start_velocity, start_acceleration;
  logic signed [qts_pkg::POS_W-1:0] end_position, end_velocity, end_acceleration;
  logic [qts_pkg::DUR_W-1:0]        duration;
  logic [qts_pkg::CNT_W-1:0]        sample_count;

  logic                             cfg_wr;
  qts_pkg::qts_reg_t                reg_sel;
  logic [qts_pkg::CNT_W-1:0]        span;
  logic                             span_zero;

  // input stage
  logic                             accept;
  qts_pkg::qts_tag_t                in_tag_next;
  logic [qts_pkg::IDX_W+qts_pkg::DUR_W-1:0] idx_prod;

  // divide chain taps, one per cell boundary
  qts_pkg::qts_tag_t                tag   [0:NCELL];
  logic [qts_pkg::REM_W-1:0]        rem_s [0:NCELL];
  logic [qts_pkg::Q_W-1:0]          ds_s  [0:NCELL];
  logic [qts_pkg::REM_W-1:0]        rem_t [0:NCELL];
  logic [qts_pkg::Q_W-1:0]          ds_t  [0:NCELL];

  qts_pkg::qts_side_t               ev_side_in, ev_side_out;
  logic [qts_pkg::Q_W-1:0]          ev_s;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign accept  = start & ~busy;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = qts_pkg::qts_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position     <= '0;
      start_velocity     <= qts_pkg::POS_W'(1) << FRACTION_BITS;
      start_acceleration <= '0;
      end_position       <= qts_pkg::POS_W'(5) << FRACTION_BITS;
      end_velocity       <= qts_pkg::POS_W'(1) << FRACTION_BITS;
      end_acceleration   <= '0;
      duration           <= qts_pkg::DUR_W'(6) << FRACTION_BITS;
      sample_count       <= qts_pkg::CNT_W'(101);
    end else if (cfg_wr) begin
      case (reg_sel)
        qts_pkg::REG_START_POS: start_position     <= pwdata;
        qts_pkg::REG_START_VEL: start_velocity     <= pwdata;
        qts_pkg::REG_START_ACC: start_acceleration <= pwdata;
        qts_pkg::REG_END_POS:   end_position       <= pwdata;
        qts_pkg::REG_END_VEL:   end_velocity       <= pwdata;
        qts_pkg::REG_END_ACC:   end_acceleration   <= pwdata;
        qts_pkg::REG_DURATION:  duration           <= pwdata[qts_pkg::DUR_W-1:0];
        qts_pkg::REG_COUNT:     sample_count       <= pwdata[qts_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      qts_pkg::REG_START_POS: prdata = start_position;
      qts_pkg::REG_START_VEL: prdata = start_velocity;
      qts_pkg::REG_START_ACC: prdata = start_acceleration;
      qts_pkg::REG_END_POS:   prdata = end_position;
      qts_pkg::REG_END_VEL:   prdata = end_velocity;
      qts_pkg::REG_END_ACC:   prdata = end_acceleration;
      qts_pkg::REG_DURATION:  prdata = {1'b0, duration};
      qts_pkg::REG_COUNT:     prdata = {21'b0, sample_count};
      default:                prdata = '0;
    endcase
  end

  assign span      = sample_count - qts_pkg::CNT_W'(1);
  assign span_zero = (sample_count == qts_pkg::CNT_W'(1));

  // classify the beat, and form the dividend of the time lane
  always_comb begin
    in_tag_next.valid = accept;
    if ({1'b0, sample_index} >= sample_count ||
        32'(sample_index) >= 32'(MAX_SAMPLES)) begin
      in_tag_next.status = qts_pkg::STATUS_BAD_INDEX;
    end else if (duration == '0) begin
      in_tag_next.status = qts_pkg::STATUS_ZERO_DUR;
    end else begin
      in_tag_next.status = qts_pkg::STATUS_OK;
    end
    idx_prod = sample_index * duration;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0].valid <= 1'b0;
    end else begin
      tag[0].valid <= in_tag_next.valid;
    end
    tag[0].status <= in_tag_next.status;
    // s lane divides idx * 2^30, time lane divides idx * duration
    rem_s[0] <= qts_pkg::REM_W'(sample_index[qts_pkg::IDX_W-1:1]);
    ds_s[0]  <= {sample_index[0], 30'b0};
    rem_t[0] <= qts_pkg::REM_W'(idx_prod[qts_pkg::IDX_W+qts_pkg::DUR_W-1:qts_pkg::Q_W]);
    ds_t[0]  <= idx_prod[qts_pkg::Q_W-1:0];
  end

  // divide chain: one quotient bit per cell for both lanes
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    qts_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .span      (span),
      .tag_in    (tag[g]),
      .rem_s_in  (rem_s[g]),
      .ds_s_in   (ds_s[g]),
      .rem_t_in  (rem_t[g]),
      .ds_t_in   (ds_t[g]),
      .tag_out   (tag[g+1]),
      .rem_s_out (rem_s[g+1]),
      .ds_s_out  (ds_s[g+1]),
      .rem_t_out (rem_t[g+1]),
      .ds_t_out  (ds_t[g+1])
    );
  end

  // single-sample trajectory sits at the start; errors report zero time
  always_comb begin
    ev_s              = span_zero ? '0 : ds_s[NCELL];
    ev_side_in.valid  = tag[NCELL].valid;
    ev_side_in.status = tag[NCELL].status;
    if (span_zero || tag[NCELL].status != qts_pkg::STATUS_OK) begin
      ev_side_in.time_q = '0;
    end else begin
      ev_side_in.time_q = ds_t[NCELL];
    end
  end

  qts_eval #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .side_in  (ev_side_in),
    .s_in     (ev_s),
    .x0       (start_position),
    .v0       (start_velocity),
    .a0       (start_acceleration),
    .xf       (end_position),
    .vf       (end_velocity),
    .af       (end_acceleration),
    .dur      (duration),
    .side_out (ev_side_out),
    .pos_out  (position)
  );

  assign done        = ev_side_out.valid;
  assign sample_time = ev_side_out.time_q;
  assign status      = ev_side_out.status;

endmodule

/* rtl/qts_div_cell.sv */
module qts_div_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [qts_pkg::CNT_W-1:0]   span,
  input  qts_pkg::qts_tag_t           tag_in,
  input  logic [qts_pkg::REM_W-1:0]   rem_s_in,
  input  logic [qts_pkg::Q_W-1:0]     ds_s_in,
  input  logic [qts_pkg::REM_W-1:0]   rem_t_in,
  input  logic [qts_pkg::Q_W-1:0]     ds_t_in,
  output qts_pkg::qts_tag_t           tag_out,
  output logic [qts_pkg::REM_W-1:0]   rem_s_out,
  output logic [qts_pkg::Q_W-1:0]     ds_s_out,
  output logic [qts_pkg::REM_W-1:0]   rem_t_out,
  output logic [qts_pkg::Q_W-1:0]     ds_t_out
);

  logic [qts_pkg::REM_W:0]   trial_s, trial_t, span_x, diff_s, diff_t;
  logic                      ge_s, ge_t;
  logic [qts_pkg::REM_W-1:0] rem_s_next, rem_t_next;

  // one restoring step per lane: bring in the next dividend bit
  always_comb begin
    span_x     = {1'b0, span};
    trial_s    = {rem_s_in, ds_s_in[qts_pkg::Q_W-1]};
    trial_t    = {rem_t_in, ds_t_in[qts_pkg::Q_W-1]};
    ge_s       = trial_s >= span_x;
    ge_t       = trial_t >= span_x;
    diff_s     = trial_s - span_x;
    diff_t     = trial_t - span_x;
    rem_s_next = ge_s ? diff_s[qts_pkg::REM_W-1:0] : trial_s[qts_pkg::REM_W-1:0];
    rem_t_next = ge_t ? diff_t[qts_pkg::REM_W-1:0] : trial_t[qts_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.status <= tag_in.status;
    rem_s_out      <= rem_s_next;
    rem_t_out      <= rem_t_next;
    ds_s_out       <= {ds_s_in[qts_pkg::Q_W-2:0], ge_s};
    ds_t_out       <= {ds_t_in[qts_pkg::Q_W-2:0], ge_t};
  end

endmodule

/* rtl/qts_smul.sv */
module qts_smul #(
  parameter int SH = qts_pkg::S_BITS
) (
  input  logic                               clk,
  input  logic signed [qts_pkg::WIDE_W-1:0]  a,
  input  logic signed [qts_pkg::WIDE_W-1:0]  b,
  output logic signed [qts_pkg::WIDE_W-1:0]  y
);

  localparam logic [qts_pkg::WIDE_W-1:0] TOP_LIMIT = 64'd1 << (61 - (32 - SH));

  logic [qts_pkg::WIDE_W-1:0] ua_full, ub;
  logic [31:0]                ua;
  logic [qts_pkg::WIDE_W-1:0] top_q, low_q, r;
  logic                       neg_q;

  // magnitudes, first operand cut to 32 bits
  always_comb begin
    ua_full = a[qts_pkg::WIDE_W-1] ? 64'(-a) : 64'(a);
    ub      = b[qts_pkg::WIDE_W-1] ? 64'(-b) : 64'(b);
    ua      = ua_full[31:0];
  end

  always_ff @(posedge clk) begin
    top_q <= 64'(ua) * 64'(ub[63:32]);
    low_q <= 64'(ua) * 64'(ub[31:0]);
    neg_q <= a[qts_pkg::WIDE_W-1] ^ b[qts_pkg::WIDE_W-1];
  end

  always_comb begin
    if (top_q >= TOP_LIMIT) begin
      r = 64'(qts_pkg::SAT_CAP);
    end else begin
      r = (top_q << (32 - SH)) + (low_q >> SH);
      if (r > 64'(qts_pkg::SAT_CAP)) begin
        r = 64'(qts_pkg::SAT_CAP);
      end
    end
  end

  always_ff @(posedge clk) begin
    y <= neg_q ? -$signed(r) : $signed(r);
  end

endmodule

/* rtl/qts_eval.sv */
module qts_eval #(
  parameter int FRACTION_BITS = qts_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  qts_pkg::qts_side_t                 side_in,
  input  logic [qts_pkg::Q_W-1:0]            s_in,
  input  logic signed [qts_pkg::POS_W-1:0]   x0,
  input  logic signed [qts_pkg::POS_W-1:0]   v0,
  input  logic signed [qts_pkg::POS_W-1:0]   a0,
  input  logic signed [qts_pkg::POS_W-1:0]   xf,
  input  logic signed [qts_pkg::POS_W-1:0]   vf,
  input  logic signed [qts_pkg::POS_W-1:0]   af,
  input  logic [qts_pkg::DUR_W-1:0]          dur,
  output qts_pkg::qts_side_t                 side_out,
  output logic signed [qts_pkg::POS_W-1:0]   pos_out
);

  localparam int NST = 13;
  localparam int SB  = qts_pkg::S_BITS;

  typedef logic signed [qts_pkg::WIDE_W-1:0] wide_t;
  typedef logic [qts_pkg::Q_W-1:0] sq_t;

  qts_pkg::qts_side_t side [1:NST];

  sq_t p1_s, p1_s2;
  sq_t p2_s, p2_s2, p2_s3;
  sq_t p3_s, p3_s2, p3_s3, p3_s4;
  sq_t p4_s, p4_s2, p4_s3, p4_s4, p4_s5;
  logic [2*qts_pkg::Q_W-1:0] m1, m2, m3, m4;

  wide_t e_s, e_s2, e_s3, e_s4, e_s5;
  wide_t h0_next, h1_next, h2_next, h3_next, h4_next, h5_next;
  wide_t h0, h1, h2, h3, h4, h5;
  wide_t tq, x0_w, v0_w, a0_w, xf_w, vf_w, af_w;
  wide_t w1, w3, u2, u4, p0, p5;
  wide_t w2, w4, pv0, pvf, pa0, paf;
  wide_t acc1, acc1_d, acc2, pvf_d, acc3, acc4, paf_d, acc5;

  assign tq   = wide_t'({33'b0, dur});
  assign x0_w = wide_t'(x0);
  assign v0_w = wide_t'(v0);
  assign a0_w = wide_t'(a0);
  assign xf_w = wide_t'(xf);
  assign vf_w = wide_t'(vf);
  assign af_w = wide_t'(af);

  // sideband delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NST; k++) begin
        side[k].valid <= 1'b0;
      end
    end else begin
      side[1].valid <= side_in.valid;
      for (int k = 2; k <= NST; k++) begin
        side[k].valid <= side[k-1].valid;
      end
    end
    side[1].status <= side_in.status;
    side[1].time_q <= side_in.time_q;
    for (int k = 2; k <= NST; k++) begin
      side[k].status <= side[k-1].status;
      side[k].time_q <= side[k-1].time_q;
    end
  end

  // powers of s, truncated q1.30
  assign m1 = s_in * s_in;
  assign m2 = p1_s2 * p1_s;
  assign m3 = p2_s3 * p2_s;
  assign m4 = p3_s4 * p3_s;

  always_ff @(posedge clk) begin
    p1_s  <= s_in;
    p1_s2 <= m1[SB+qts_pkg::Q_W-1:SB];
    p2_s  <= p1_s;
    p2_s2 <= p1_s2;
    p2_s3 <= m2[SB+qts_pkg::Q_W-1:SB];
    p3_s  <= p2_s;
    p3_s2 <= p2_s2;
    p3_s3 <= p2_s3;
    p3_s4 <= m3[SB+qts_pkg::Q_W-1:SB];
    p4_s  <= p3_s;
    p4_s2 <= p3_s2;
    p4_s3 <= p3_s3;
    p4_s4 <= p3_s4;
    p4_s5 <= m4[SB+qts_pkg::Q_W-1:SB];
  end

  // hermite basis
  always_comb begin
    e_s     = wide_t'({33'b0, p4_s});
    e_s2    = wide_t'({33'b0, p4_s2});
    e_s3    = wide_t'({33'b0, p4_s3});
    e_s4    = wide_t'({33'b0, p4_s4});
    e_s5    = wide_t'({33'b0, p4_s5});
    h5_next = 64'sd10 * e_s3 - 64'sd15 * e_s4 + 64'sd6 * e_s5;
    h0_next = (64'sd1 <<< SB) - h5_next;
    h1_next = e_s - 64'sd6 * e_s3 + 64'sd8 * e_s4 - 64'sd3 * e_s5;
    h2_next = (e_s2 - 64'sd3 * e_s3 + 64'sd3 * e_s4 - e_s5) / 64'sd2;
    h3_next = -64'sd4 * e_s3 + 64'sd7 * e_s4 - 64'sd3 * e_s5;
    h4_next = (e_s3 - 64'sd2 * e_s4 + e_s5) / 64'sd2;
  end

  always_ff @(posedge clk) begin
    h0 <= h0_next;
    h1 <= h1_next;
    h2 <= h2_next;
    h3 <= h3_next;
    h4 <= h4_next;
    h5 <= h5_next;
  end

  // first product layer
  qts_smul #(.SH(SB)) u_w1 (.clk(clk), .a(h1),   .b(tq), .y(w1));
  qts_smul #(.SH(SB)) u_w3 (.clk(clk), .a(h3),   .b(tq), .y(w3));
  qts_smul #(.SH(SB)) u_u2 (.clk(clk), .a(h2),   .b(tq), .y(u2));
  qts_smul #(.SH(SB)) u_u4 (.clk(clk), .a(h4),   .b(tq), .y(u4));
  qts_smul #(.SH(SB)) u_p0 (.clk(clk), .a(x0_w), .b(h0), .y(p0));
  qts_smul #(.SH(SB)) u_p5 (.clk(clk), .a(xf_w), .b(h5), .y(p5));

  // second product layer
  qts_smul #(.SH(FRACTION_BITS)) u_w2  (.clk(clk), .a(u2),   .b(tq), .y(w2));
  qts_smul #(.SH(FRACTION_BITS)) u_w4  (.clk(clk), .a(u4),   .b(tq), .y(w4));
  qts_smul #(.SH(FRACTION_BITS)) u_pv0 (.clk(clk), .a(v0_w), .b(w1), .y(pv0));
  qts_smul #(.SH(FRACTION_BITS)) u_pvf (.clk(clk), .a(vf_w), .b(w3), .y(pvf));

  // third product layer
  qts_smul #(.SH(FRACTION_BITS)) u_pa0 (.clk(clk), .a(a0_w), .b(w2), .y(pa0));
  qts_smul #(.SH(FRACTION_BITS)) u_paf (.clk(clk), .a(af_w), .b(w4), .y(paf));

  // saturating sum, in the fixed term order
  assign acc5 = qts_pkg::sat_add(acc4, paf_d);

  always_ff @(posedge clk) begin
    acc1   <= qts_pkg::sat_add(p0, p5);
    acc1_d <= acc1;
    acc2   <= qts_pkg::sat_add(acc1_d, pv0);
    pvf_d  <= pvf;
    acc3   <= qts_pkg::sat_add(acc2, pvf_d);
    acc4   <= qts_pkg::sat_add(acc3, pa0);
    paf_d  <= paf;
    if (side[12].status != qts_pkg::STATUS_OK) begin
      pos_out <= '0;
    end else if (acc5 > 64'sd2147483647) begin
      pos_out <= 32'sh7fffffff;
    end else if (acc5 < -64'sd2147483648) begin
      pos_out <= 32'sh80000000;
    end else begin
      pos_out <= acc5[qts_pkg::POS_W-1:0];
    end
  end

  assign side_out = side[NST];

endmodule

/* tb/sv/qts_checker.sv */
`timescale 1ns / 1ps
module qts_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [9:0]  sample_index,
  input  logic        done,
  input  logic [30:0] sample_time,
  input  logic signed [31:0] position,
  input  logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [30:0] t;
    logic signed [31:0] pos;
    logic [1:0] st;
  } sample_t;

  localparam longint CAP = 64'sd1 <<< 61;
  localparam int EXP_DEPTH = 64;

  longint x0, v0, a0, xf, vf, af;
  longint unsigned dur, cnt;

  // expected beats in flight, oldest at rd_ptr
  sample_t exp_mem [0:EXP_DEPTH-1];
  logic [5:0] wr_ptr, rd_ptr;
  int fill;
  logic cmd_beat, res_pop;

  function automatic longint cap(longint v);
    if (v > CAP) return CAP;
    if (v < -CAP) return -CAP;
    return v;
  endfunction

  // truncating magnitude product, saturating at the cap
  function automatic longint fx_mul(longint a, longint b, int sh);
    logic neg;
    longint unsigned ua, ub, top, r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    ua = ua & 64'hffffffff;
    top = ua * (ub >> 32);
    if (top >= (64'd1 << (61 - (32 - sh)))) r = CAP;
    else r = (top << (32 - sh)) + ((ua * (ub & 64'hffffffff)) >> sh);
    if (r > CAP) r = CAP;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic sample_t trajectory_sample(logic [9:0] idx);
    sample_t o;
    longint unsigned span, s, s2, s3, s4, s5;
    longint h0, h1, h2, h3, h4, h5, tq, acc;
    o.t = '0; o.pos = '0; o.st = qts_pkg::STATUS_OK;
    if (idx >= cnt) begin
      o.st = qts_pkg::STATUS_BAD_INDEX;
      return o;
    end
    if (dur == 0) begin
      o.st = qts_pkg::STATUS_ZERO_DUR;
      return o;
    end
    span = cnt - 1;
    if (span == 0) begin
      s = 0;
    end else begin
      s = (longint'(idx) << 30) / span;
      o.t = 31'((longint'(idx) * dur) / span);
    end
    s2 = (s * s) >> 30;
    s3 = (s2 * s) >> 30;
    s4 = (s3 * s) >> 30;
    s5 = (s4 * s) >> 30;
    h5 = 10 * s3 - 15 * longint'(s4) + 6 * s5;
    h0 = (64'sd1 << 30) - h5;
    h1 = longint'(s) - 6 * longint'(s3) + 8 * longint'(s4) - 3 * longint'(s5);
    h2 = (longint'(s2) - 3 * longint'(s3) + 3 * longint'(s4) - longint'(s5)) / 2;
    h3 = -4 * longint'(s3) + 7 * longint'(s4) - 3 * longint'(s5);
    h4 = (longint'(s3) - 2 * longint'(s4) + longint'(s5)) / 2;
    tq = dur;
    acc = fx_mul(x0, h0, 30);
    acc = cap(acc + fx_mul(xf, h5, 30));
    acc = cap(acc + fx_mul(v0, fx_mul(h1, tq, 30), 16));
    acc = cap(acc + fx_mul(vf, fx_mul(h3, tq, 30), 16));
    acc = cap(acc + fx_mul(a0, fx_mul(fx_mul(h2, tq, 30), tq, 16), 16));
    acc = cap(acc + fx_mul(af, fx_mul(fx_mul(h4, tq, 30), tq, 16), 16));
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    o.pos = acc[31:0];
    return o;
  endfunction

  assign pending  = fill;
  assign cmd_beat = start && !busy;
  assign res_pop  = done && (fill != 0);

  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      x0 <= 0; v0 <= 64'sd65536; a0 <= 0; xf <= 64'sd327680; vf <= 64'sd65536; af <= 0;
      dur <= 393216; cnt <= 101;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= 0;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (qts_pkg::qts_reg_t'(paddr[4:2]))
          qts_pkg::REG_START_POS: x0 <= longint'(signed'(pwdata));
          qts_pkg::REG_START_VEL: v0 <= longint'(signed'(pwdata));
          qts_pkg::REG_START_ACC: a0 <= longint'(signed'(pwdata));
          qts_pkg::REG_END_POS:   xf <= longint'(signed'(pwdata));
          qts_pkg::REG_END_VEL:   vf <= longint'(signed'(pwdata));
          qts_pkg::REG_END_ACC:   af <= longint'(signed'(pwdata));
          qts_pkg::REG_DURATION:  dur <= pwdata[30:0];
          qts_pkg::REG_COUNT:     cnt <= pwdata[10:0];
          default: ;
        endcase
      end
      if (cmd_beat) begin
        exp_mem[wr_ptr] <= trajectory_sample(sample_index);
        wr_ptr <= wr_ptr + 6'd1;
      end
      if (done) begin
        if (fill == 0) begin
          $display("%0t unexpected beat: time %0d pos %0d status %0d",
                   $time, sample_time, position, status);
          fail_count <= fail_count + 1;
        end else begin
          e = exp_mem[rd_ptr];
          rd_ptr <= rd_ptr + 6'd1;
          if (e.t !== sample_time || e.pos !== position || e.st !== status) begin
            $display("%0t exp time %0d pos %0d status %0d, got time %0d pos %0d status %0d",
                     $time, e.t, e.pos, e.st, sample_time, position, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      fill <= fill + (cmd_beat ? 1 : 0) - (res_pop ? 1 : 0);
    end
  end
endmodule

/* tb/sv/tb_quintic_trajectory_sampler_core.sv */
`timescale 1ns / 1ps
module tb_quintic_trajectory_sampler_core;

  localparam int LATENCY = 45;
  localparam int STALL_LIMIT = 2000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [9:0] sample_index = '0;
  logic done;
  logic [30:0] sample_time;
  logic signed [31:0] position;
  logic [1:0] status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_cycles;
  int sender_gap_pct;

  always #5 clk = ~clk;

  quintic_trajectory_sampler_core DUT (.*);

  qts_checker u_checker (.*);

  // watchdog: counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("quintic_trajectory_sampler_core: mismatch");
      $finish;
    end
  end

  task automatic reg_write(qts_pkg::qts_reg_t r, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // one command beat, with random hold-off per current gap rate
  task automatic send_index(logic [9:0] idx);
    while ($urandom_range(99, 0) < sender_gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; sample_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drain results, then let the pipeline settle before touching config
  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] p0, v0, a0, pf, vf, af, logic [30:0] d,
                             logic [10:0] n);
    reg_write(qts_pkg::REG_START_POS, p0);
    reg_write(qts_pkg::REG_START_VEL, v0);
    reg_write(qts_pkg::REG_START_ACC, a0);
    reg_write(qts_pkg::REG_END_POS, pf);
    reg_write(qts_pkg::REG_END_VEL, vf);
    reg_write(qts_pkg::REG_END_ACC, af);
    reg_write(qts_pkg::REG_DURATION, {1'b0, d});
    reg_write(qts_pkg::REG_COUNT, {21'd0, n});
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(20 << 16, 0)) - (10 << 16);
    endcase
  endfunction

  initial begin
    int n;
    int cnt;
    sender_gap_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset defaults, ends, out of range
    send_index(0); send_index(50); send_index(100); send_index(101);
    send_index(10'h3ff); send_index(10'h2aa); send_index(10'h155);
    drain();
    // zero duration, bad index still wins
    load_config(0, 0, 0, 0, 0, 0, 0, 11'd8);
    send_index(3); send_index(8);
    drain();
    // extremes, maximum count and duration
    load_config(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 31'h7fffffff, 11'd1024);
    send_index(0); send_index(511); send_index(1023); send_index(1);
    drain();
    // two-sample count, single-sample count, and zero count
    load_config(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 31'd1, 11'd2);
    send_index(0); send_index(1); send_index(2);
    drain();
    load_config(32'h12345678, 0, 0, 0, 0, 0, 31'd65536, 11'd1);
    send_index(0); send_index(1);
    drain();
    load_config(0, 0, 0, 0, 0, 0, 31'd65536, 11'd0);
    send_index(0);
    drain();
    // count past the index range
    load_config(0, 32'd65536, 0, 32'd65536, 0, 0, 31'd65536, 11'h7ff);
    send_index(10'h3ff);
    drain();

    // random phases with varied idling
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 3)
        0: sender_gap_pct = 0;
        1: sender_gap_pct = 82;
        default: sender_gap_pct = 7;
      endcase
      cnt = (ph == 4) ? 1024 : $urandom_range(40, 2);
      load_config(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                  (ph == 7) ? 31'd0 :
                  31'($urandom_range(1, 0) ? $urandom : $urandom_range(20 << 16, 1)),
                  11'(cnt));
      n = 95;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9, 0) == 0) send_index(10'($urandom));
        else send_index(10'($urandom_range(cnt - 1, 0)));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("quintic_trajectory_sampler_core: match");
    end else begin
      $display("quintic_trajectory_sampler_core: mismatch");
    end
    $finish;
  end
endmodule
